FILE: rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LSB steganography embedder.
// ----------------------------------------------------------------------------
package lse_pkg;

  typedef logic [2:0]  phase_t;
  typedef logic [35:0] pos_t;

  // Phase codes, in stream order
  localparam phase_t PH_HEADER = 3'd0;
  localparam phase_t PH_MAGIC  = 3'd1;
  localparam phase_t PH_EXTLEN = 3'd2;
  localparam phase_t PH_EXT    = 3'd3;
  localparam phase_t PH_SIZE   = 3'd4;
  localparam phase_t PH_DATA   = 3'd5;
  localparam phase_t PH_TRAIL  = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_EXT_LEN  = 2'd1;
  localparam logic [1:0] REG_EXT_CHAR = 2'd2;
  localparam logic [1:0] REG_SIZE     = 2'd3;

  // Field lengths in bits of the fixed frame fields
  localparam pos_t MAGIC_BITS  = 36'd16;
  localparam pos_t EXTLEN_BITS = 36'd32;
  localparam pos_t SIZE_BITS   = 36'd32;

  // Reset value of the marker: '#*'
  localparam logic [15:0] MAGIC_RESET = 16'h232A;

  // Keeps all bits of a cover byte but the LSB
  localparam logic [7:0] LSB_CLEAR_MASK = 8'hFE;

endpackage

FILE: rtl/lsb_stego_embedder_core.sv
// ----------------------------------------------------------------------------
// lsb_stego_embedder_core
// Hides a framed payload in the LSBs of a cover byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one word per item. A word
//   with kind 0 is a cover byte and gives one output word; a word with kind 1
//   loads the held secret byte and gives no output. The output channel
//   (out_valid/out_ready) returns the stego byte, the phase that byte belonged
//   to and secret_wanted, which asks for the next secret byte before the next
//   cover byte.
//   out_valid rises in the cycle after a cover byte is accepted. Throughput
//   is one word per cycle without a stall: the phase/position update is a
//   single compare, increment and compare between state and output registers.
//   When the receiver stalls, the output register holds its word and in_ready
//   drops until it is taken; in_ready stays high while the output register is
//   empty or being drained in the same cycle.
//   Reset (rst, synchronous) empties the output register, returns to the
//   header phase at position zero, clears the held secret byte and loads the
//   register defaults. The user writes registers through cfg_we/cfg_index/
//   cfg_data only while no word is in flight; the block does not check it.
// ----------------------------------------------------------------------------
module lsb_stego_embedder_core #(
  parameter int HEADER_BYTES  = 54,
  parameter int MAX_EXT_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  cover_byte,
  input  logic [7:0]  secret_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  stego_byte,
  output logic [2:0]  phase,
  output logic        secret_wanted
);

  localparam logic [3:0]    MaxExt   = 4'(MAX_EXT_CHARS);
  localparam lse_pkg::pos_t HdrBytes = 36'(HEADER_BYTES);

  // Configuration registers
  logic [15:0] magic_word;
  logic [3:0]  ext_length;
  logic [63:0] ext_chars;
  logic [31:0] data_bytes;

  // Stream state
  lse_pkg::phase_t phase_reg;
  lse_pkg::pos_t   bit_position;
  logic [7:0]      held_secret;

  lse_pkg::phase_t phase_next;
  lse_pkg::pos_t   bit_position_next;

  logic [3:0]      eff_ext_len;
  logic            skip_ext;
  logic            skip_data;
  lse_pkg::phase_t cur_ph;
  lse_pkg::pos_t   cur_pos;
  lse_pkg::pos_t   cur_pos_inc;
  lse_pkg::pos_t   pre_len;
  lse_pkg::pos_t   post_len;
  logic            pay_bit;
  logic [31:0]     ext_len_word;
  logic [7:0]      stego_next;
  logic            wanted_next;
  logic            in_fire;
  logic            out_fire;

  // Length in cover bytes of a phase under the current registers
  function automatic lse_pkg::pos_t phase_len(input lse_pkg::phase_t ph,
                                              input logic [3:0] ext_n,
                                              input logic [31:0] fsize);
    lse_pkg::pos_t len;
    case (ph)
      lse_pkg::PH_HEADER: len = HdrBytes;
      lse_pkg::PH_MAGIC:  len = lse_pkg::MAGIC_BITS;
      lse_pkg::PH_EXTLEN: len = lse_pkg::EXTLEN_BITS;
      lse_pkg::PH_EXT:    len = {29'd0, ext_n, 3'd0};
      lse_pkg::PH_SIZE:   len = lse_pkg::SIZE_BITS;
      lse_pkg::PH_DATA:   len = {1'b0, fsize, 3'd0};
      default:            len = '0;
    endcase
    return len;
  endfunction

  // Next phase that is not empty; only ext and data can be empty
  function automatic lse_pkg::phase_t next_phase(input lse_pkg::phase_t ph,
                                                 input logic s_ext,
                                                 input logic s_data);
    lse_pkg::phase_t n;
    n = ph + 3'd1;
    if (n == lse_pkg::PH_EXT && s_ext) begin
      n = lse_pkg::PH_SIZE;
    end
    if (n == lse_pkg::PH_DATA && s_data) begin
      n = lse_pkg::PH_TRAIL;
    end
    if (ph >= lse_pkg::PH_TRAIL) begin
      n = lse_pkg::PH_TRAIL;
    end
    return n;
  endfunction

  // Saturate the extension length
  assign eff_ext_len  = (ext_length > MaxExt) ? MaxExt : ext_length;
  assign skip_ext     = (eff_ext_len == 4'd0);
  assign skip_data    = (data_bytes == 32'd0);
  assign ext_len_word = {28'd0, eff_ext_len};

  // Handshake: the output register parts the two sides
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Settle the stored state against the current registers
  assign pre_len = phase_len(phase_reg, eff_ext_len, data_bytes);

  always_comb begin
    if (phase_reg >= lse_pkg::PH_TRAIL) begin
      cur_ph      = lse_pkg::PH_TRAIL;
      cur_pos     = '0;
      cur_pos_inc = '0;
    end else if (bit_position >= pre_len) begin
      cur_ph      = next_phase(phase_reg, skip_ext, skip_data);
      cur_pos     = '0;
      cur_pos_inc = 36'd1;
    end else begin
      cur_ph      = phase_reg;
      cur_pos     = bit_position;
      cur_pos_inc = bit_position + 36'd1;
    end
  end

  // Pick the payload bit for this position
  always_comb begin
    case (cur_ph)
      lse_pkg::PH_MAGIC:  pay_bit = magic_word[~cur_pos[3:0]];
      lse_pkg::PH_EXTLEN: pay_bit = ext_len_word[~cur_pos[4:0]];
      lse_pkg::PH_EXT:    pay_bit = ext_chars[~cur_pos[5:0]];
      lse_pkg::PH_SIZE:   pay_bit = data_bytes[~cur_pos[4:0]];
      default:            pay_bit = held_secret[~cur_pos[2:0]];
    endcase
  end

  // Insert the bit outside header and trailing phases
  always_comb begin
    if (cur_ph == lse_pkg::PH_HEADER || cur_ph == lse_pkg::PH_TRAIL) begin
      stego_next = cover_byte;
    end else begin
      stego_next = (cover_byte & lse_pkg::LSB_CLEAR_MASK) | {7'd0, pay_bit};
    end
  end

  // Advance the position and settle again
  assign post_len = phase_len(cur_ph, eff_ext_len, data_bytes);

  always_comb begin
    if (cur_ph >= lse_pkg::PH_TRAIL) begin
      phase_next        = lse_pkg::PH_TRAIL;
      bit_position_next = '0;
    end else if (cur_pos_inc >= post_len) begin
      phase_next        = next_phase(cur_ph, skip_ext, skip_data);
      bit_position_next = '0;
    end else begin
      phase_next        = cur_ph;
      bit_position_next = cur_pos_inc;
    end
  end

  assign wanted_next = (phase_next == lse_pkg::PH_DATA) && (bit_position_next[2:0] == 3'd0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= lse_pkg::MAGIC_RESET;
      ext_length <= '0;
      ext_chars  <= '0;
      data_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lse_pkg::REG_MAGIC:    magic_word <= cfg_data[15:0];
        lse_pkg::REG_EXT_LEN:  ext_length <= cfg_data[3:0];
        lse_pkg::REG_EXT_CHAR: ext_chars  <= cfg_data;
        lse_pkg::REG_SIZE:     data_bytes <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Stream state: load secret bytes, advance on cover bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= lse_pkg::PH_HEADER;
      bit_position <= '0;
      held_secret  <= '0;
    end else if (in_fire) begin
      if (kind) begin
        held_secret <= secret_byte;
      end else begin
        phase_reg    <= phase_next;
        bit_position <= bit_position_next;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && !kind) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire && !kind) begin
      stego_byte    <= stego_next;
      phase         <= cur_ph;
      secret_wanted <= wanted_next;
    end
  end

  // Trailing phase always sits at position zero
  a_trail_pos: assert property (@(posedge clk) disable iff (rst)
    phase_reg == lse_pkg::PH_TRAIL |-> bit_position == '0)
    else $error("trailing phase with nonzero position");

  // Phase never moves backward outside reset
  a_phase_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> phase_reg >= $past(phase_reg))
    else $error("phase moved backward");

  // An accepted cover byte always shows up in the output register
  a_cover_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> out_valid)
    else $error("cover byte lost");

  // A secret byte load leaves the phase untouched
  a_secret_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind |=> $stable(phase_reg) && $stable(bit_position))
    else $error("secret byte load moved the stream state");

endmodule
